@@ hdl/hrc_pkg.sv @@
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants for the client handshake sequencer.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TtlW   = 31;
  localparam int unsigned FailW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] BackoffBaseRst = 32'd500;
  localparam logic [TimeW-1:0] BackoffCapRst  = 32'd8000;
  localparam logic [TtlW-1:0]  WantTtlRst     = 31'd10000;
  localparam logic [TtlW-1:0]  StepTimeoutRst = 31'd8000;
  localparam logic [FailW-1:0] FailMax        = 8'd255;
  localparam logic [TimeW-1:0] WakeNone       = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_RESOLVING = 3'd1,
    ST_SIGMA1    = 3'd2,
    ST_SIGMA3    = 3'd3,
    ST_READY     = 3'd4,
    ST_BACKOFF   = 3'd5
  } link_state_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESOLVE = 2'd1,
    ACT_SIGMA1  = 2'd2,
    ACT_INVOKE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_POLL         = 4'd0,
    OP_WANT         = 4'd1,
    OP_RESOLVED     = 4'd2,
    OP_SENT         = 4'd3,
    OP_SIGMA2       = 4'd4,
    OP_ESTABLISHED  = 4'd5,
    OP_INVOKED      = 4'd6,
    OP_FAILED       = 4'd7,
    OP_SESSION_LOST = 4'd8,
    OP_OBSERVE      = 4'd9
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BACKOFF_BASE = 2'd0,
    CFG_BACKOFF_CAP  = 2'd1,
    CFG_WANT_TTL     = 2'd2,
    CFG_STEP_TIMEOUT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [3:0]       opcode;
    logic [TimeW-1:0] now_time;
    logic             success;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       action;
    logic             want_live;
    logic [TimeW-1:0] next_wake_ms;
    logic [2:0]       link_state;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] backoff_base_ms;
    logic [TimeW-1:0] backoff_cap_ms;
    logic [TtlW-1:0]  want_ttl_ms;
    logic [TtlW-1:0]  step_timeout_ms;
  } hrc_cfg_t;

  typedef struct packed {
    link_state_t      fsm_state;
    logic             want_pending;
    logic [TimeW-1:0] want_time;
    logic             peer_known;
    logic [TimeW-1:0] step_deadline;
    logic [TimeW-1:0] retry_time;
    logic [FailW-1:0] fail_count;
  } hrc_state_t;

endpackage

@@ hdl/hrc_step.sv @@
// ----------------------------------------------------------------------------
// hrc_step
// Combinational step: next sequencer state and result beat for one event.
// ----------------------------------------------------------------------------
module hrc_step import hrc_pkg::*; (
  input  hrc_cfg_t   cfg,
  input  hrc_state_t cur,
  input  in_item_t   item,
  output hrc_state_t nxt,
  output out_item_t  res
);

  // Wrap-safe: reached when the sign bit of (now - when) is clear.
  function automatic logic time_reached(input logic [TimeW-1:0] now,
                                        input logic [TimeW-1:0] when);
    logic [TimeW-1:0] diff;
    diff = now - when;
    return ~diff[TimeW-1];
  endfunction

  function automatic logic [TimeW-1:0] time_until(input logic [TimeW-1:0] now,
                                                  input logic [TimeW-1:0] when);
    return time_reached(now, when) ? '0 : (when - now);
  endfunction

  logic [TimeW-1:0] now;
  logic [TimeW-1:0] ttl_ext;
  logic [TimeW-1:0] tmo_ext;
  logic [TimeW-1:0] want_end;
  logic [TimeW-1:0] want_end_nxt;
  logic [TimeW-1:0] left_ms;
  logic [TimeW-1:0] lookup_span;
  logic             live_now;
  logic [FailW-1:0] fail_inc;
  logic [FailW-1:0] shift_k;
  logic [2*TimeW-1:0] shifted;
  logic             shift_over;
  logic [TimeW-1:0] delay_ms;
  logic             do_fail;
  logic             do_idle;
  action_t          act;

  assign now      = item.now_time;
  assign ttl_ext  = {1'b0, cfg.want_ttl_ms};
  assign tmo_ext  = {1'b0, cfg.step_timeout_ms};
  assign want_end = cur.want_time + ttl_ext;
  assign live_now = cur.want_pending && !time_reached(now, want_end);
  assign left_ms  = time_until(now, want_end);
  assign lookup_span = (left_ms < tmo_ext) ? left_ms : tmo_ext;

  // Retry delay: base doubled (count - 1) times, clamped to the cap.
  assign fail_inc = (cur.fail_count < FailMax) ? cur.fail_count + 1'b1 : cur.fail_count;
  assign shift_k  = fail_inc - 1'b1;
  assign shifted  = {{TimeW{1'b0}}, cfg.backoff_base_ms} << shift_k[4:0];
  assign shift_over = (|shift_k[FailW-1:5]) || (|shifted[2*TimeW-1:TimeW]) ||
                      (shifted[TimeW-1:0] > cfg.backoff_cap_ms);
  assign delay_ms = (cfg.backoff_base_ms == '0) ? '0 :
                    shift_over ? cfg.backoff_cap_ms : shifted[TimeW-1:0];

  always_comb begin
    nxt     = cur;
    act     = ACT_NONE;
    do_fail = 1'b0;
    do_idle = 1'b0;
    case (opcode_t'(item.opcode))
      OP_POLL: begin
        if (cur.want_pending && !live_now) nxt.want_pending = 1'b0;
        case (cur.fsm_state)
          ST_IDLE: do_idle = 1'b1;
          ST_RESOLVING, ST_SIGMA1, ST_SIGMA3: begin
            if (time_reached(now, cur.step_deadline)) do_fail = 1'b1;
          end
          ST_READY: act = nxt.want_pending ? ACT_INVOKE : ACT_NONE;
          ST_BACKOFF: begin
            if (time_reached(now, cur.retry_time)) begin
              nxt.fsm_state = ST_IDLE;
              do_idle       = 1'b1;
            end
          end
          default: ;
        endcase
        if (do_idle && nxt.want_pending) begin
          if (cur.peer_known) begin
            act = ACT_SIGMA1;
          end else begin
            act               = ACT_RESOLVE;
            nxt.fsm_state     = ST_RESOLVING;
            nxt.step_deadline = now + lookup_span;
          end
        end
      end
      OP_WANT: begin
        nxt.want_pending = 1'b1;
        nxt.want_time    = now;
      end
      OP_RESOLVED: begin
        if (item.success) begin
          nxt.peer_known = 1'b1;
          nxt.fsm_state  = ST_IDLE;
        end else begin
          nxt.peer_known = 1'b0;
          do_fail        = 1'b1;
        end
      end
      OP_SENT: begin
        if (cur.fsm_state == ST_IDLE) nxt.fsm_state = ST_SIGMA1;
        else if (cur.fsm_state == ST_SIGMA1) nxt.fsm_state = ST_SIGMA3;
        nxt.step_deadline = now + tmo_ext;
      end
      OP_SIGMA2: begin
        if (cur.fsm_state == ST_SIGMA1) nxt.step_deadline = now + tmo_ext;
      end
      OP_ESTABLISHED: begin
        nxt.fsm_state  = ST_READY;
        nxt.fail_count = '0;
      end
      OP_INVOKED: begin
        nxt.want_pending = 1'b0;
        if (item.success) nxt.fail_count = '0;
      end
      OP_FAILED: do_fail = 1'b1;
      OP_SESSION_LOST: begin
        if (cur.fsm_state == ST_READY) nxt.fsm_state = ST_IDLE;
      end
      default: ;  // observe and unused codes: no change
    endcase
    if (do_fail) begin
      nxt.fail_count = fail_inc;
      nxt.fsm_state  = ST_BACKOFF;
      nxt.retry_time = now + delay_ms;
    end
  end

  assign want_end_nxt = nxt.want_time + ttl_ext;

  always_comb begin
    res.action     = act;
    res.want_live  = nxt.want_pending && !time_reached(now, want_end_nxt);
    res.link_state = nxt.fsm_state;
    case (nxt.fsm_state)
      ST_RESOLVING, ST_SIGMA1, ST_SIGMA3: res.next_wake_ms = time_until(now, nxt.step_deadline);
      ST_BACKOFF: res.next_wake_ms = nxt.want_pending ? time_until(now, nxt.retry_time) : WakeNone;
      ST_IDLE, ST_READY: res.next_wake_ms = nxt.want_pending ? '0 : WakeNone;
      default: res.next_wake_ms = WakeNone;
    endcase
  end

endmodule

@@ hdl/handshake_retry_client_fsm.sv @@
// ----------------------------------------------------------------------------
// handshake_retry_client_fsm
// Client handshake sequencer: lookup, sigma1, sigma3, ready, retry backoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one event beat: opcode,
//   millisecond timestamp and an ok flag. Each beat yields exactly one result
//   beat on out_valid/out_stall/out_data: poll action, want liveness, wait
//   to the next deadline (all-ones = none) and the state after the step.
//   A beat lands in the input register, then its result in the
//   output register. Throughput: one beat per cycle unless the
//   receiver stalls; the whole step is one pass of adds, compares
//   and a clamped shift in hrc_step, between the two registers.
//   When the receiver stalls, the result holds and the input register keeps
//   its beat; in_stall rises only once both registers are full.
//   Config (cfg_we/cfg_index/cfg_wdata) writes one register per edge. The user
//   must write it only with no beat in flight; the block does not enforce it.
//   Reset (rst_n low, synchronous) empties both registers, puts the
//   sequencer in idle with no want and no known peer, and loads default
//   config: base 500 ms, cap 8000 ms, want TTL 10000 ms, step 8000 ms.
// ----------------------------------------------------------------------------
module handshake_retry_client_fsm import hrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [TimeW-1:0]     cfg_wdata
);

  // Config registers
  hrc_cfg_t   cfg_r;

  // Sequencer state
  hrc_state_t st_r;
  hrc_state_t st_nxt;

  // Input register (stage 1) and result register (stage 2)
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  out_item_t  res_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic       s1_fire;   // stage 1 beat is processed and moves to output
  logic       in_fire;

  // Stage 1 moves on whenever the output register is empty or draining.
  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backoff_base_ms <= BackoffBaseRst;
      cfg_r.backoff_cap_ms  <= BackoffCapRst;
      cfg_r.want_ttl_ms     <= WantTtlRst;
      cfg_r.step_timeout_ms <= StepTimeoutRst;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BACKOFF_BASE: cfg_r.backoff_base_ms <= cfg_wdata;
        CFG_BACKOFF_CAP:  cfg_r.backoff_cap_ms  <= cfg_wdata;
        CFG_WANT_TTL:     cfg_r.want_ttl_ms     <= cfg_wdata[TtlW-1:0];
        CFG_STEP_TIMEOUT: cfg_r.step_timeout_ms <= cfg_wdata[TtlW-1:0];
        default: ;
      endcase
    end
  end

  hrc_step u_step (
    .cfg  (cfg_r),
    .cur  (st_r),
    .item (s1_item_r),
    .nxt  (st_nxt),
    .res  (res_nxt)
  );

  // State only advances when a beat leaves stage 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.fsm_state     <= ST_IDLE;
      st_r.want_pending  <= 1'b0;
      st_r.want_time     <= '0;
      st_r.peer_known    <= 1'b0;
      st_r.step_deadline <= '0;
      st_r.retry_time    <= '0;
      st_r.fail_count    <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)      s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (s1_fire)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r  <= in_data;
    if (s1_fire) out_data_r <= res_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Only poll may request an action.
  a_action_poll_only: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.opcode != OP_POLL) |=> out_data_r.action == ACT_NONE)
    else $error("action on a non-poll event");

  // Failure count saturates instead of wrapping.
  a_fail_sat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (st_r.fail_count == FailMax) && (s1_item_r.opcode == OP_FAILED)
    |=> st_r.fail_count == FailMax && st_r.fsm_state == ST_BACKOFF)
    else $error("fail count wrapped");

  // Established lands in ready with the failure count cleared.
  a_established: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.opcode == OP_ESTABLISHED)
    |=> st_r.fsm_state == ST_READY && st_r.fail_count == '0 && out_valid_r)
    else $error("established did not reach ready");

  // Reported state always matches the sequencer state after the step.
  a_state_report: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_data_r.link_state == st_r.fsm_state)
    else $error("reported link state mismatch");

endmodule
